// ===== hdl/mlfq_pkg.sv =====
// Shared types, codes and reset constants of the multilevel feedback queue scheduler.
package mlfq_pkg;

  // default sizing
  localparam int LEVELS_DEF    = 4;
  localparam int MAX_PROCS_DEF = 16;

  // fixed field widths
  localparam int LVL_W   = 2;
  localparam int ID_W    = 8;
  localparam int BURST_W = 16;
  localparam int SLICE_W = 8;
  localparam int BI_W    = 16;
  localparam int TIME_W  = 32;
  localparam int ENTRY_W = ID_W + BURST_W;
  localparam int NUM_SLICES = 4;

  // configuration register indexes
  localparam logic [2:0] CFG_SLICE0 = 3'd0;
  localparam logic [2:0] CFG_SLICE1 = 3'd1;
  localparam logic [2:0] CFG_SLICE2 = 3'd2;
  localparam logic [2:0] CFG_SLICE3 = 3'd3;
  localparam logic [2:0] CFG_BOOST  = 3'd4;

  // register reset values
  localparam logic [SLICE_W-1:0] SLICE_RST [NUM_SLICES] = '{8'd1, 8'd2, 8'd4, 8'd8};
  localparam logic [BI_W-1:0]    BOOST_RST = 16'd10;

  // request actions
  localparam logic ACT_ADMIT    = 1'b0;
  localparam logic ACT_DISPATCH = 1'b1;

  typedef enum logic [2:0] {
    STAT_ADMITTED,
    STAT_FULL,
    STAT_REQUEUED,
    STAT_FINISHED,
    STAT_IDLE
  } status_t;

  typedef struct packed {
    logic               action;
    logic [ID_W-1:0]    proc_id;
    logic [BURST_W-1:0] burst_len;
  } mlfq_in_t;

  typedef struct packed {
    status_t            status;
    logic [ID_W-1:0]    ran_id;
    logic [SLICE_W-1:0] ran_time;
    logic [LVL_W-1:0]   from_level;
    logic [BURST_W-1:0] left_time;
    logic               boosted;
    logic [TIME_W-1:0]  now_time;
  } mlfq_out_t;

  // remainder unit control
  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] dividend;
    logic [BI_W-1:0]   divisor;
  } mlfq_rem_req_t;

  typedef struct packed {
    logic done;
    logic zero;
  } mlfq_rem_resp_t;

endpackage

// ===== hdl/mlfq_rem.sv =====
// Bit-serial remainder unit: tells whether the scheduler time is a multiple of the boost interval.
module mlfq_rem (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mlfq_pkg::mlfq_rem_req_t  req,
  output mlfq_pkg::mlfq_rem_resp_t resp
);
  import mlfq_pkg::*;

  localparam int STEPS  = TIME_W;
  localparam int STEP_W = $clog2(STEPS);

  logic              run_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [TIME_W-1:0] dvd_r;
  logic [BI_W-1:0]   div_r;
  logic [BI_W-1:0]   rem_r;

  logic [BI_W:0] trial;
  logic          ge;
  logic [BI_W:0] rem_nxt;

  // one restoring step: shift in the next dividend bit, subtract when it fits
  always_comb begin
    trial   = {rem_r, dvd_r[TIME_W-1]};
    ge      = trial >= {1'b0, div_r};
    rem_nxt = ge ? trial - {1'b0, div_r} : trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r  <= 1'b1;
        step_r <= '0;
        dvd_r  <= req.dividend;
        div_r  <= req.divisor;
        rem_r  <= '0;
      end else if (run_r) begin
        rem_r  <= rem_nxt[BI_W-1:0];
        dvd_r  <= {dvd_r[TIME_W-2:0], 1'b0};
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign resp.done = done_r;
  assign resp.zero = (rem_r == '0);

endmodule

// ===== hdl/multilevel_feedback_queue_scheduler.sv =====
// Multilevel feedback queue scheduler top level: queue memory, level pointers and sequencer.
//
//   channel | ports                                   | flow
//   --------+-----------------------------------------+-----------------------------------
//   request | start, busy, in_item                    | taken when start && !busy
//   result  | out_valid, out_item                     | one-cycle strobe, cannot be held off
//   config  | cfg_valid, cfg_ready, cfg_index, cfg_data | written when cfg_valid && cfg_ready
//
// Admit, and dispatch with all levels empty: result in the next cycle, no busy time.
// Dispatch: the queue memory read, then the update of the popped entry, then the bit-serial
// remainder unit (skipped when boost_interval is 0); a boost moves the entries of levels 1 and up
// to level 0 one read and one write at a time, all through the single queue memory port pair.
// Reset is synchronous; the queue memory holds no reset and needs no clearing pass.
// busy is high from a dispatch request until its result strobe.
module multilevel_feedback_queue_scheduler #(
  parameter int LEVELS    = mlfq_pkg::LEVELS_DEF,
  parameter int MAX_PROCS = mlfq_pkg::MAX_PROCS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mlfq_pkg::mlfq_in_t  in_item,
  output logic                out_valid,
  output mlfq_pkg::mlfq_out_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import mlfq_pkg::*;

  localparam int DEPTH  = LEVELS * MAX_PROCS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SLOT_W = $clog2(MAX_PROCS);
  localparam int CNT_W  = $clog2(MAX_PROCS + 1);
  localparam int TOT_W  = CNT_W + 2;
  localparam int LIDX_W = $clog2(LEVELS);
  localparam int BJ_W   = $clog2(LEVELS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISP_RUN,
    ST_MOD_WAIT,
    ST_BOOST_RD,
    ST_BOOST_WR
  } state_t;

  state_t state_r;

  // queue memory and its read register
  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_raddr;

  // level pointers
  logic [SLOT_W-1:0] head_r [LEVELS];
  logic [SLOT_W-1:0] tail_r [LEVELS];
  logic [CNT_W-1:0]  cnt_r  [LEVELS];
  logic [TIME_W-1:0] clock_r;

  // configuration
  logic [SLICE_W-1:0] slice_r [NUM_SLICES];
  logic [BI_W-1:0]    interval_r;

  // dispatch bookkeeping
  logic [LVL_W-1:0]   cur_lvl_r;
  logic [BJ_W-1:0]    bj_r;
  status_t            res_status_r;
  logic [ID_W-1:0]    res_id_r;
  logic [SLICE_W-1:0] res_run_r;
  logic [BURST_W-1:0] res_left_r;

  logic           out_valid_r;
  mlfq_out_t      out_item_r;
  mlfq_rem_req_t  rem_req_r;
  mlfq_rem_resp_t rem_resp;

  // combinational helpers
  logic               accept;
  logic [TOT_W-1:0]   total_cnt;
  logic               full;
  logic               found;
  logic [LVL_W-1:0]   fl;
  logic [BURST_W-1:0] rem_t;
  logic [SLICE_W-1:0] slice_cur;
  logic [SLICE_W-1:0] run_len;
  logic [BURST_W-1:0] left_len;
  logic [LVL_W-1:0]   dst;
  logic [TIME_W-1:0]  clock_new;
  logic [LIDX_W-1:0]  bj_idx;
  logic               bj_done;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [LVL_W-1:0] lvl,
                                                input logic [SLOT_W-1:0] slot);
    return ADDR_W'(lvl) * ADDR_W'(MAX_PROCS) + ADDR_W'(slot);
  endfunction

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(MAX_PROCS - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign bj_idx    = bj_r[LIDX_W-1:0];
  assign bj_done   = (bj_r == BJ_W'(LEVELS));

  // occupancy total and lowest-numbered (highest-priority) non-empty level
  always_comb begin
    total_cnt = '0;
    found     = 1'b0;
    fl        = '0;
    for (int l = 0; l < LEVELS; l++) begin
      total_cnt = total_cnt + TOT_W'(cnt_r[l]);
    end
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (cnt_r[l] != '0) begin
        found = 1'b1;
        fl    = LVL_W'(l);
      end
    end
    full = (total_cnt >= TOT_W'(MAX_PROCS));
  end

  // run length, remaining time and destination level of the popped entry
  always_comb begin
    rem_t     = rd_data_r[BURST_W-1:0];
    slice_cur = slice_r[cur_lvl_r];
    run_len   = ({8'b0, slice_cur} < rem_t) ? slice_cur : rem_t[SLICE_W-1:0];
    left_len  = rem_t - {8'b0, run_len};
    dst       = (cur_lvl_r == LVL_W'(LEVELS - 1)) ? cur_lvl_r : cur_lvl_r + LVL_W'(1);
    clock_new = clock_r + {24'b0, run_len};
  end

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_item.action == ACT_ADMIT && !full) begin
          mem_we    = 1'b1;
          mem_waddr = addr_of('0, tail_r[0]);
          mem_wdata = {in_item.proc_id, in_item.burst_len};
        end
        if (accept && in_item.action == ACT_DISPATCH && found) begin
          mem_re    = 1'b1;
          mem_raddr = addr_of(fl, head_r[fl[LIDX_W-1:0]]);
        end
      end
      ST_DISP_RUN: begin
        if (left_len != '0) begin
          mem_we    = 1'b1;
          mem_waddr = addr_of(dst, tail_r[dst[LIDX_W-1:0]]);
          mem_wdata = {rd_data_r[ENTRY_W-1:BURST_W], left_len};
        end
      end
      ST_BOOST_RD: begin
        if (!bj_done && cnt_r[bj_idx] != '0) begin
          mem_re    = 1'b1;
          mem_raddr = addr_of(LVL_W'(bj_r), head_r[bj_idx]);
        end
      end
      ST_BOOST_WR: begin
        mem_we    = 1'b1;
        mem_waddr = addr_of('0, tail_r[0]);
        mem_wdata = rd_data_r;
      end
      default: begin
      end
    endcase
  end

  // queue memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLICES; i++) begin
        slice_r[i] <= SLICE_RST[i];
      end
      interval_r <= BOOST_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index) inside
        [CFG_SLICE0:CFG_SLICE3]: slice_r[cfg_index[1:0]] <= cfg_data[SLICE_W-1:0];
        CFG_BOOST:               interval_r <= cfg_data[BI_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer with level pointers and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      out_valid_r     <= 1'b0;
      rem_req_r.start <= 1'b0;
      clock_r         <= '0;
      bj_r            <= '0;
      for (int l = 0; l < LEVELS; l++) begin
        head_r[l] <= '0;
        tail_r[l] <= '0;
        cnt_r[l]  <= '0;
      end
    end else begin
      out_valid_r     <= 1'b0;
      rem_req_r.start <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept && in_item.action == ACT_ADMIT) begin
            out_valid_r <= 1'b1;
            out_item_r  <= '{status: full ? STAT_FULL : STAT_ADMITTED,
                             ran_id: in_item.proc_id, ran_time: '0, from_level: '0,
                             left_time: '0, boosted: 1'b0, now_time: clock_r};
            if (!full) begin
              tail_r[0] <= slot_inc(tail_r[0]);
              cnt_r[0]  <= cnt_r[0] + CNT_W'(1);
            end
          end else if (accept) begin
            if (found) begin
              head_r[fl[LIDX_W-1:0]] <= slot_inc(head_r[fl[LIDX_W-1:0]]);
              cnt_r[fl[LIDX_W-1:0]]  <= cnt_r[fl[LIDX_W-1:0]] - CNT_W'(1);
              cur_lvl_r              <= fl;
              state_r                <= ST_DISP_RUN;
            end else begin
              out_valid_r <= 1'b1;
              out_item_r  <= '{status: STAT_IDLE, ran_id: '0, ran_time: '0,
                               from_level: '0, left_time: '0, boosted: 1'b0,
                               now_time: clock_r};
            end
          end
        end
        ST_DISP_RUN: begin
          clock_r      <= clock_new;
          res_id_r     <= rd_data_r[ENTRY_W-1:BURST_W];
          res_run_r    <= run_len;
          res_left_r   <= left_len;
          res_status_r <= (left_len == '0) ? STAT_FINISHED : STAT_REQUEUED;
          if (left_len != '0) begin
            tail_r[dst[LIDX_W-1:0]] <= slot_inc(tail_r[dst[LIDX_W-1:0]]);
            cnt_r[dst[LIDX_W-1:0]]  <= cnt_r[dst[LIDX_W-1:0]] + CNT_W'(1);
          end
          if (interval_r != '0) begin
            rem_req_r <= '{start: 1'b1, dividend: clock_new, divisor: interval_r};
            state_r   <= ST_MOD_WAIT;
          end else begin
            out_valid_r <= 1'b1;
            out_item_r  <= '{status: (left_len == '0) ? STAT_FINISHED : STAT_REQUEUED,
                             ran_id: rd_data_r[ENTRY_W-1:BURST_W], ran_time: run_len,
                             from_level: cur_lvl_r, left_time: left_len, boosted: 1'b0,
                             now_time: clock_new};
            state_r     <= ST_IDLE;
          end
        end
        ST_MOD_WAIT: begin
          if (rem_resp.done) begin
            if (rem_resp.zero) begin
              bj_r    <= BJ_W'(1);
              state_r <= ST_BOOST_RD;
            end else begin
              out_valid_r <= 1'b1;
              out_item_r  <= '{status: res_status_r, ran_id: res_id_r, ran_time: res_run_r,
                               from_level: cur_lvl_r, left_time: res_left_r,
                               boosted: 1'b0, now_time: clock_r};
              state_r     <= ST_IDLE;
            end
          end
        end
        ST_BOOST_RD: begin
          if (bj_done) begin
            out_valid_r <= 1'b1;
            out_item_r  <= '{status: res_status_r, ran_id: res_id_r, ran_time: res_run_r,
                             from_level: cur_lvl_r, left_time: res_left_r,
                             boosted: 1'b1, now_time: clock_r};
            state_r     <= ST_IDLE;
          end else if (cnt_r[bj_idx] == '0) begin
            // level drained: its ring restarts at slot zero
            head_r[bj_idx] <= '0;
            tail_r[bj_idx] <= '0;
            bj_r           <= bj_r + BJ_W'(1);
          end else begin
            head_r[bj_idx] <= slot_inc(head_r[bj_idx]);
            cnt_r[bj_idx]  <= cnt_r[bj_idx] - CNT_W'(1);
            state_r        <= ST_BOOST_WR;
          end
        end
        ST_BOOST_WR: begin
          tail_r[0] <= slot_inc(tail_r[0]);
          cnt_r[0]  <= cnt_r[0] + CNT_W'(1);
          state_r   <= ST_BOOST_RD;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  mlfq_rem u_rem (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (rem_req_r),
    .resp (rem_resp)
  );

`ifndef NO_ASSERTIONS
  // the queues together never hold more than the process limit
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    total_cnt <= TOT_W'(MAX_PROCS))
    else $error("queue occupancy above limit");

  // a result strobe always coincides with the sequencer being back at rest
  a_out_rest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result while busy");

  // an admit request is answered in the next cycle
  a_admit_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.action == ACT_ADMIT) |=> out_valid)
    else $error("admit without result");

  // the remainder unit finishes only while the sequencer waits for it
  a_rem_done: assert property (@(posedge clk) disable iff (!rst_n)
    rem_resp.done |-> state_r == ST_MOD_WAIT)
    else $error("stray remainder completion");
`endif

endmodule
